[design/segx_pkg.sv]
// Package for the 2D segment intersection block.
// Holds the widths, the reset value of the tolerance register and the saturation helper.
// Depends on nothing; used by segment_intersection_2d.
package segx_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int PT_FRAC         = 8;
   localparam int L_W             = 32;
   localparam int PT_W            = 24;
   localparam int TOL_W           = 16;
   localparam int QUO_W           = 32;
   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

   typedef struct packed {
      logic par;
      logic l_neg;
      logic m_neg;
      logic x_neg;
      logic y_neg;
   } side_type;

   typedef struct packed {
      logic [QUO_W-1:0] v;
      logic             clip;
   } sat_type;

   function automatic sat_type sat_code(logic [QUO_W-1:0] q, logic ovf, logic neg,
                                        logic [5:0] w);
      logic [QUO_W:0] lim;
      logic [QUO_W:0] m;
      sat_type        r;
      lim    = ((QUO_W+1)'(1) << (w - 6'd1)) - (QUO_W+1)'(!neg);
      r.clip = ovf || ({1'b0, q} > lim);
      m      = r.clip ? lim : {1'b0, q};
      r.v    = neg ? QUO_W'(-m) : QUO_W'(m);
      return r;
   endfunction

endpackage

[design/segx_div.sv]
// Pipelined restoring divider: round(mag * 2^SHIFT / dmag), one quotient bit per stage.
// Flags a quotient that does not fit in QW bits. Uses segx_pkg for nothing but is
// instantiated by segment_intersection_2d.
module segx_div #(
   parameter int MW    = 35,
   parameter int DMW   = 35,
   parameter int SHIFT = 16,
   parameter int QW    = 32
) (
   input  logic            clock,
   input  logic            en,
   input  logic [MW-1:0]   mag,
   input  logic [DMW-1:0]  dmag,
   output logic [QW-1:0]   quo,
   output logic            ovf
);

   localparam int NW  = ((MW + SHIFT + 1) > DMW ? (MW + SHIFT + 1) : DMW) + 1;
   localparam int NEW = NW > QW ? NW : QW + 1;
   localparam int HW  = NEW - QW;
   localparam int DW  = DMW + 1;
   localparam int CW  = HW > DW ? HW : DW;

   logic [NEW-1:0] n_ff;
   logic [DW-1:0]  d_ff;
   logic [CW-1:0]  hi_ext;

   logic [DW-1:0] rem_ff [0:QW-1];
   logic [QW-1:0] lo_ff  [0:QW-1];
   logic [DW-1:0] dd_ff  [0:QW-1];
   logic [QW-1:0] q_ff   [0:QW];
   logic          ovf_ff [0:QW];

   assign hi_ext = CW'(n_ff[NEW-1:QW]);

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff      <= NEW'({mag, (SHIFT + 1)'(0)}) + NEW'(dmag);
         d_ff      <= {dmag, 1'b0};
         rem_ff[0] <= DW'(hi_ext);
         lo_ff[0]  <= n_ff[QW-1:0];
         dd_ff[0]  <= d_ff;
         q_ff[0]   <= '0;
         ovf_ff[0] <= hi_ext >= CW'(d_ff);
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_stage
      logic [DW:0] sh;
      logic [DW:0] diff;
      logic        ge;
      assign sh   = {rem_ff[k-1], lo_ff[k-1][QW-1]};
      assign ge   = sh >= {1'b0, dd_ff[k-1]};
      assign diff = sh - {1'b0, dd_ff[k-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k]   <= {q_ff[k-1][QW-2:0], ge};
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
      if (k < QW) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= ge ? diff[DW-1:0] : sh[DW-1:0];
               lo_ff[k]  <= {lo_ff[k-1][QW-2:0], 1'b0};
               dd_ff[k]  <= dd_ff[k-1];
            end
         end
      end
   end

   assign quo = q_ff[QW];
   assign ovf = ovf_ff[QW];

endmodule

[design/segment_intersection_2d.sv]
// Top level of the 2D segment intersection block: Cramer's rule front end, four
// pipelined dividers, saturation and hit test. Depends on segx_pkg and segx_div.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  p1, p2, q1, q2 coordinates
//   rsp      out        rsp_valid / rsp_stall  hit, parallel, l, m, cross point, clipped
//   csr      in         csr_valid / csr_ready  tolerance
//
// One request enters per cycle while req_stall is low; its result passes through six front
// end stages of multiply and add, QUO_W + 2 divider stages and the output register.
// A stalled result holds every stage; req_stall is high exactly then.
// Reset clears the valid bits and sets the tolerance to one.
module segment_intersection_2d #(
   parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = segx_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COORD_WIDTH-1:0]        req_p1_x,
   input  logic signed [COORD_WIDTH-1:0]        req_p1_y,
   input  logic signed [COORD_WIDTH-1:0]        req_p2_x,
   input  logic signed [COORD_WIDTH-1:0]        req_p2_y,
   input  logic signed [COORD_WIDTH-1:0]        req_q1_x,
   input  logic signed [COORD_WIDTH-1:0]        req_q1_y,
   input  logic signed [COORD_WIDTH-1:0]        req_q2_x,
   input  logic signed [COORD_WIDTH-1:0]        req_q2_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hit,
   output logic                                 rsp_parallel,
   output logic signed [segx_pkg::L_W-1:0]      rsp_l_param,
   output logic signed [segx_pkg::L_W-1:0]      rsp_m_param,
   output logic signed [segx_pkg::PT_W-1:0]     rsp_cross_x,
   output logic signed [segx_pkg::PT_W-1:0]     rsp_cross_y,
   output logic                                 rsp_clipped,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [segx_pkg::TOL_W-1:0]           csr_data
);

   localparam int DFW = COORD_WIDTH + 1;
   localparam int PRW = 2 * DFW;
   localparam int SW  = PRW + 1;
   localparam int PXW = SW + COORD_WIDTH;
   localparam int LXW = SW + DFW;
   localparam int XW  = SW + DFW + 1;
   localparam int QW  = segx_pkg::QUO_W;
   localparam int DLY = QW + 2;
   localparam int HW  = segx_pkg::L_W + 2;

   logic adv;
   logic [segx_pkg::TOL_W-1:0] tol_ff;

   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= segx_pkg::TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_data;
      end
   end

   // Front end registers.
   logic [6:1] v_ff;
   logic signed [DFW-1:0] ax_ff1, ay_ff1, bx_ff1, by_ff1, rx_ff1, ry_ff1;
   logic signed [COORD_WIDTH-1:0] p2x_ff1, p2y_ff1, p2x_ff2, p2y_ff2, p2x_ff3, p2y_ff3;
   logic signed [DFW-1:0] ax_ff2, ay_ff2, ax_ff3, ay_ff3;
   logic signed [PRW-1:0] axby_ff, bxay_ff, rxby_ff, bxry_ff, axry_ff, rxay_ff;
   logic signed [SW-1:0] det_ff, nl_ff, nm_ff;
   logic signed [PXW-1:0] px_ff, py_ff;
   logic signed [LXW-1:0] lx_ff, ly_ff;
   logic [SW-1:0] dmag_ff4, lmag_ff4, mmag_ff4, dmag_ff5, lmag_ff5, mmag_ff5;
   logic [SW-1:0] dmag_ff6, lmag_ff6, mmag_ff6;
   logic par_ff4, lneg_ff4, mneg_ff4, dneg_ff4;
   logic par_ff5, lneg_ff5, mneg_ff5, dneg_ff5;
   logic signed [XW-1:0] nx_ff, ny_ff;
   logic [XW-1:0] xmag_ff, ymag_ff;
   segx_pkg::side_type side6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[5:1], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff1  <= DFW'(req_p1_x) - DFW'(req_p2_x);
         ay_ff1  <= DFW'(req_p1_y) - DFW'(req_p2_y);
         bx_ff1  <= DFW'(req_q2_x) - DFW'(req_q1_x);
         by_ff1  <= DFW'(req_q2_y) - DFW'(req_q1_y);
         rx_ff1  <= DFW'(req_q2_x) - DFW'(req_p2_x);
         ry_ff1  <= DFW'(req_q2_y) - DFW'(req_p2_y);
         p2x_ff1 <= req_p2_x;
         p2y_ff1 <= req_p2_y;

         axby_ff <= PRW'(ax_ff1) * PRW'(by_ff1);
         bxay_ff <= PRW'(bx_ff1) * PRW'(ay_ff1);
         rxby_ff <= PRW'(rx_ff1) * PRW'(by_ff1);
         bxry_ff <= PRW'(bx_ff1) * PRW'(ry_ff1);
         axry_ff <= PRW'(ax_ff1) * PRW'(ry_ff1);
         rxay_ff <= PRW'(rx_ff1) * PRW'(ay_ff1);
         ax_ff2  <= ax_ff1;
         ay_ff2  <= ay_ff1;
         p2x_ff2 <= p2x_ff1;
         p2y_ff2 <= p2y_ff1;

         det_ff  <= SW'(axby_ff) - SW'(bxay_ff);
         nl_ff   <= SW'(rxby_ff) - SW'(bxry_ff);
         nm_ff   <= SW'(axry_ff) - SW'(rxay_ff);
         ax_ff3  <= ax_ff2;
         ay_ff3  <= ay_ff2;
         p2x_ff3 <= p2x_ff2;
         p2y_ff3 <= p2y_ff2;

         px_ff    <= PXW'(det_ff) * PXW'(p2x_ff3);
         py_ff    <= PXW'(det_ff) * PXW'(p2y_ff3);
         lx_ff    <= LXW'(nl_ff) * LXW'(ax_ff3);
         ly_ff    <= LXW'(nl_ff) * LXW'(ay_ff3);
         dmag_ff4 <= det_ff[SW-1] ? SW'(-det_ff) : SW'(det_ff);
         lmag_ff4 <= nl_ff[SW-1] ? SW'(-nl_ff) : SW'(nl_ff);
         mmag_ff4 <= nm_ff[SW-1] ? SW'(-nm_ff) : SW'(nm_ff);
         par_ff4  <= det_ff == '0;
         dneg_ff4 <= det_ff[SW-1];
         lneg_ff4 <= nl_ff[SW-1] ^ det_ff[SW-1];
         mneg_ff4 <= nm_ff[SW-1] ^ det_ff[SW-1];

         nx_ff    <= XW'(px_ff) + XW'(lx_ff);
         ny_ff    <= XW'(py_ff) + XW'(ly_ff);
         dmag_ff5 <= dmag_ff4;
         lmag_ff5 <= lmag_ff4;
         mmag_ff5 <= mmag_ff4;
         par_ff5  <= par_ff4;
         dneg_ff5 <= dneg_ff4;
         lneg_ff5 <= lneg_ff4;
         mneg_ff5 <= mneg_ff4;

         xmag_ff        <= nx_ff[XW-1] ? XW'(-nx_ff) : XW'(nx_ff);
         ymag_ff        <= ny_ff[XW-1] ? XW'(-ny_ff) : XW'(ny_ff);
         dmag_ff6       <= dmag_ff5;
         lmag_ff6       <= lmag_ff5;
         mmag_ff6       <= mmag_ff5;
         side6_ff.par   <= par_ff5;
         side6_ff.l_neg <= lneg_ff5;
         side6_ff.m_neg <= mneg_ff5;
         side6_ff.x_neg <= nx_ff[XW-1] ^ dneg_ff5;
         side6_ff.y_neg <= ny_ff[XW-1] ^ dneg_ff5;
      end
   end

   // Dividers.
   logic [QW-1:0] lq, mq, xq, yq;
   logic          lovf, movf, xovf, yovf;

   segx_div #(.MW(SW), .DMW(SW), .SHIFT(FRAC_BITS), .QW(QW)) u_div_l (
      .clock(clock), .en(adv), .mag(lmag_ff6), .dmag(dmag_ff6), .quo(lq), .ovf(lovf));
   segx_div #(.MW(SW), .DMW(SW), .SHIFT(FRAC_BITS), .QW(QW)) u_div_m (
      .clock(clock), .en(adv), .mag(mmag_ff6), .dmag(dmag_ff6), .quo(mq), .ovf(movf));
   segx_div #(.MW(XW), .DMW(SW), .SHIFT(segx_pkg::PT_FRAC), .QW(QW)) u_div_x (
      .clock(clock), .en(adv), .mag(xmag_ff), .dmag(dmag_ff6), .quo(xq), .ovf(xovf));
   segx_div #(.MW(XW), .DMW(SW), .SHIFT(segx_pkg::PT_FRAC), .QW(QW)) u_div_y (
      .clock(clock), .en(adv), .mag(ymag_ff), .dmag(dmag_ff6), .quo(yq), .ovf(yovf));

   logic               dv_ff   [0:DLY-1];
   segx_pkg::side_type side_ff [0:DLY-1];

   for (genvar k = 0; k < DLY; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (adv) begin
            dv_ff[k] <= (k == 0) ? v_ff[6] : dv_ff[(k == 0) ? 0 : k - 1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k] <= (k == 0) ? side6_ff : side_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   // Saturation and hit test.
   segx_pkg::side_type sd;
   segx_pkg::sat_type  ls, ms, xs, ys;
   logic signed [HW-1:0] lw, mw, tw, ow;
   logic hit_in;

   always_comb begin
      sd = side_ff[DLY-1];
      ls = segx_pkg::sat_code(lq, lovf, sd.l_neg, 6'(segx_pkg::L_W));
      ms = segx_pkg::sat_code(mq, movf, sd.m_neg, 6'(segx_pkg::L_W));
      xs = segx_pkg::sat_code(xq, xovf, sd.x_neg, 6'(segx_pkg::PT_W));
      ys = segx_pkg::sat_code(yq, yovf, sd.y_neg, 6'(segx_pkg::PT_W));
      lw = HW'($signed(ls.v[segx_pkg::L_W-1:0]));
      mw = HW'($signed(ms.v[segx_pkg::L_W-1:0]));
      tw = $signed(HW'(tol_ff));
      ow = $signed(HW'(1) << FRAC_BITS);
      hit_in = (lw >= -tw) && (lw <= ow + tw) && (mw >= -tw) && (mw < ow + tw);
   end

   logic rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_ff[DLY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_parallel <= sd.par;
         if (sd.par) begin
            rsp_hit     <= 1'b0;
            rsp_l_param <= '0;
            rsp_m_param <= '0;
            rsp_cross_x <= '0;
            rsp_cross_y <= '0;
            rsp_clipped <= 1'b0;
         end else begin
            rsp_hit     <= hit_in;
            rsp_l_param <= ls.v[segx_pkg::L_W-1:0];
            rsp_m_param <= ms.v[segx_pkg::L_W-1:0];
            rsp_cross_x <= xs.v[segx_pkg::PT_W-1:0];
            rsp_cross_y <= ys.v[segx_pkg::PT_W-1:0];
            rsp_clipped <= ls.clip || ms.clip || xs.clip || ys.clip;
         end
      end
   end

`ifndef SYNTHESIS
   a_parallel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parallel |-> !rsp_hit && rsp_l_param == '0 && rsp_m_param == '0
         && rsp_cross_x == '0 && rsp_cross_y == '0 && !rsp_clipped)
      else $error("parallel result carries nonzero fields");
   a_hit_not_parallel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_parallel)
      else $error("hit reported on parallel segments");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
   a_held_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall ##1 (rsp_valid
         && $stable({rsp_hit, rsp_parallel, rsp_l_param, rsp_m_param, rsp_cross_x,
                     rsp_cross_y, rsp_clipped})))
      else $error("stalled result lost or pipeline not held");
`endif

endmodule
